// ===== hdl/lfu_pkg.sv =====
// Shared constants and default cell interface types for the LFU cache directory.
package lfu_pkg;

  localparam int ENTRIES_DEFAULT    = 16;
  localparam int KEY_BITS_DEFAULT   = 32;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 32;
  localparam int SLOT_W   = 4;
  localparam int USE_W    = 16;

  localparam int IN_W  = 96;
  localparam int OUT_W = 120;

  localparam int IDX_W_DEFAULT  = 4;
  localparam int FILL_W_DEFAULT = 5;

  typedef struct packed {
    logic                          hit;
    logic [IDX_W_DEFAULT-1:0]      hit_idx;
    logic [HANDLE_W-1:0]           hit_handle;
    logic [LENGTH_W-1:0]           hit_length;
    logic [COUNT_BITS_DEFAULT-1:0] hit_count;
    logic                          min_ok;
    logic [IDX_W_DEFAULT-1:0]      min_idx;
    logic [COUNT_BITS_DEFAULT-1:0] min_count;
    logic [KEY_BITS_DEFAULT-1:0]   min_key;
  } carry_t;

  typedef struct packed {
    logic [FILL_W_DEFAULT-1:0]   fill;
    logic [FILL_W_DEFAULT-1:0]   cap;
    logic [KEY_BITS_DEFAULT-1:0] key;
    logic [HANDLE_W-1:0]         handle;
    logic [LENGTH_W-1:0]         length;
    logic                        wr;
    logic                        bump;
    logic [IDX_W_DEFAULT-1:0]    idx;
  } cmd_t;

endpackage

// ===== hdl/lfu_cache_policy.sv =====
// Top level of the LFU cache directory: item handshake, control sequencer and the row of slots.
// Each access passes through the SEARCH and DECIDE states from input transfer to result: the
// search carry walks the row of slot cells one cell per cycle, comparing the key and tracking
// the least-used slot among the first capacity slots, then the DECIDE state writes or bumps
// the chosen slot and registers the result once the result register is free. One access is
// handled at a time; the next input transfer is taken once the previous result has been
// registered, and the result register lets the next access run while the result waits to be
// taken. Capacity is written through cfg_we/cfg_wdata; the user must write it only while no
// access is in progress, as the block itself does not enforce it.
module lfu_cache_policy #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEFAULT,
  parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEFAULT,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,  // capacity
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // key[31:0], content_handle[63:32], content_length[95:64]
  input  logic [lfu_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // hit[0], slot[4:1], inserted[5], evicted[6], evicted_key[38:7], out_handle[70:39],
  // out_length[102:71], use_count[118:103], zero[119]
  output logic [lfu_pkg::OUT_W-1:0] m_tdata
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > lfu_pkg::CAP_W) ? FILL_W : lfu_pkg::CAP_W;

  typedef struct packed {
    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [lfu_pkg::HANDLE_W-1:0]  hit_handle;
    logic [lfu_pkg::LENGTH_W-1:0]  hit_length;
    logic [COUNT_BITS-1:0]         hit_count;
    logic                          min_ok;
    logic [IDX_W-1:0]              min_idx;
    logic [COUNT_BITS-1:0]         min_count;
    logic [KEY_BITS-1:0]           min_key;
  } row_carry_t;

  typedef struct packed {
    logic [FILL_W-1:0]            fill;
    logic [FILL_W-1:0]            cap;
    logic [KEY_BITS-1:0]          key;
    logic [lfu_pkg::HANDLE_W-1:0] handle;
    logic [lfu_pkg::LENGTH_W-1:0] length;
    logic                         wr;
    logic                         bump;
    logic [IDX_W-1:0]             idx;
  } row_cmd_t;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    DECIDE
  } state_t;

  state_t                       state;
  logic [lfu_pkg::CAP_W-1:0]    capacity;
  logic [FILL_W-1:0]            fill;
  logic [IDX_W-1:0]             cnt;
  logic [KEY_BITS-1:0]          item_key;
  logic [lfu_pkg::HANDLE_W-1:0] item_handle;
  logic [lfu_pkg::LENGTH_W-1:0] item_length;

  logic [CMP_W-1:0]        cap_wide;
  logic [FILL_W-1:0]       cap;
  row_cmd_t                cmd;
  row_carry_t              carry_head;
  row_carry_t              carry [ENTRIES];
  row_carry_t              res;
  logic                    fire;
  logic                    free_slot;
  logic                    do_ins;
  logic                    do_evict;
  logic [IDX_W-1:0]        widx;
  logic [COUNT_BITS-1:0]   count_after;
  logic [lfu_pkg::OUT_W-1:0] result;

  assign cap_wide   = CMP_W'(capacity);
  assign cap        = (cap_wide > CMP_W'(ENTRIES)) ? FILL_W'(ENTRIES) : FILL_W'(cap_wide);
  assign carry_head = '0;
  assign res        = carry[ENTRIES-1];
  assign s_tready   = state == IDLE;
  assign fire       = (state == DECIDE) && (!m_tvalid || m_tready);
  assign free_slot  = fill < cap;
  assign do_ins     = !res.hit && cap != '0;
  assign do_evict   = do_ins && !free_slot;

  always_comb begin
    if (res.hit) begin
      widx = res.hit_idx;
    end else if (free_slot) begin
      widx = IDX_W'(fill);
    end else begin
      widx = res.min_idx;
    end
    if (res.hit) begin
      count_after = (res.hit_count == {COUNT_BITS{1'b1}}) ? res.hit_count
                                                           : res.hit_count + COUNT_BITS'(1);
    end else if (do_ins) begin
      count_after = COUNT_BITS'(1);
    end else begin
      count_after = '0;
    end
  end

  always_comb begin
    cmd.fill   = fill;
    cmd.cap    = cap;
    cmd.key    = item_key;
    cmd.handle = item_handle;
    cmd.length = item_length;
    cmd.wr     = fire && do_ins;
    cmd.bump   = fire && res.hit;
    cmd.idx    = widx;
  end

  always_comb begin
    result = '0;
    result[0]       = res.hit;
    result[4:1]     = (res.hit || do_ins) ? lfu_pkg::SLOT_W'(widx) : '0;
    result[5]       = do_ins;
    result[6]       = do_evict;
    result[38:7]    = do_evict ? lfu_pkg::KEY_W'(res.min_key) : '0;
    result[70:39]   = res.hit ? res.hit_handle : item_handle;
    result[102:71]  = res.hit ? res.hit_length : item_length;
    result[118:103] = lfu_pkg::USE_W'(count_after);
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_row
    row_carry_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = carry_head;
    end else begin : g_link
      assign cell_in = carry[i-1];
    end
    lfu_cell #(
      .INDEX      (i),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W),
      .FILL_W     (FILL_W),
      .carry_t    (row_carry_t),
      .cmd_t      (row_cmd_t)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .carry_in  (cell_in),
      .carry_out (carry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      capacity <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
      fill     <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            item_key    <= KEY_BITS'(s_tdata[31:0]);
            item_handle <= s_tdata[63:32];
            item_length <= s_tdata[95:64];
            cnt         <= '0;
            state       <= SEARCH;
          end
        end
        SEARCH: begin
          if (cnt == IDX_W'(ENTRIES - 1)) begin
            state <= DECIDE;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        DECIDE: begin
          if (fire) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            if (do_ins && free_slot) begin
              fill <= fill + FILL_W'(1);
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(ENTRIES))
    else $error("fill count beyond slot count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && free_slot) |=> fill == $past(fill) + FILL_W'(1))
    else $error("fill count not advanced on insertion into a free slot");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!(m_tdata[0] && m_tdata[5]) && (!m_tdata[6] || m_tdata[5])))
    else $error("inconsistent hit, inserted and evicted flags");
`endif

endmodule

// ===== hdl/lfu_cell.sv =====
// One directory slot: stores an entry and folds it into the search carry passed along the row.
module lfu_cell #(
  parameter int  INDEX      = 0,
  parameter int  KEY_BITS   = lfu_pkg::KEY_BITS_DEFAULT,
  parameter int  COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT,
  parameter int  IDX_W      = lfu_pkg::IDX_W_DEFAULT,
  parameter int  FILL_W     = lfu_pkg::FILL_W_DEFAULT,
  parameter type carry_t    = lfu_pkg::carry_t,
  parameter type cmd_t      = lfu_pkg::cmd_t
) (
  input  logic   clk,
  input  cmd_t   cmd,
  input  carry_t carry_in,
  output carry_t carry_out
);

  logic [KEY_BITS-1:0]          key_q;
  logic [lfu_pkg::HANDLE_W-1:0] handle_q;
  logic [lfu_pkg::LENGTH_W-1:0] length_q;
  logic [COUNT_BITS-1:0]        count_q;

  logic   filled;
  logic   in_cap;
  logic   selected;
  carry_t carry_next;

  assign filled   = FILL_W'(INDEX) < cmd.fill;
  assign in_cap   = FILL_W'(INDEX) < cmd.cap;
  assign selected = cmd.idx == IDX_W'(INDEX);

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.hit && filled && key_q == cmd.key) begin
      carry_next.hit        = 1'b1;
      carry_next.hit_idx    = IDX_W'(INDEX);
      carry_next.hit_handle = handle_q;
      carry_next.hit_length = length_q;
      carry_next.hit_count  = count_q;
    end
    if (in_cap && (!carry_in.min_ok || count_q < carry_in.min_count)) begin
      carry_next.min_ok    = 1'b1;
      carry_next.min_idx   = IDX_W'(INDEX);
      carry_next.min_count = count_q;
      carry_next.min_key   = key_q;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
    if (selected && cmd.wr) begin
      key_q    <= cmd.key;
      handle_q <= cmd.handle;
      length_q <= cmd.length;
      count_q  <= COUNT_BITS'(1);
    end else if (selected && cmd.bump && count_q != {COUNT_BITS{1'b1}}) begin
      count_q <= count_q + COUNT_BITS'(1);
    end
  end

endmodule
